// ===== hdl/mpbf_pkg.sv =====
// shared types, field widths and defaults for the marker boundary finder
`default_nettype none

package mpbf_pkg;

	localparam int NUM_MARKERS_DEF    = 8;
	localparam int MAX_MARKER_LEN_DEF = 32;
	localparam int POS_BITS_DEF       = 24;

	localparam int SLOT_W = 3;
	localparam int OFFS_W = 5;
	localparam int PLEN_W = 6;
	localparam int BYTE_W = 8;
	localparam int CFG_W  = 4;
	localparam int MIDX_W = 3;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_SCAN = 1'b1
	} mode_t;

	typedef struct packed {
		mode_t              mode;
		logic [SLOT_W-1:0]  slot;
		logic [OFFS_W-1:0]  offs;
		logic [PLEN_W-1:0]  plen;
		logic [BYTE_W-1:0]  data;
		logic               last;
	} item_t;

	// one item leaving the input register this cycle
	typedef struct packed {
		logic load;
		logic scan;
		logic last;
	} step_t;

	typedef struct packed {
		logic flushing;
		logic res_room;
	} trk_status_t;

endpackage

`default_nettype wire

// ===== hdl/mpbf_marker_table.sv =====
// marker byte table and per-slot marker lengths, written by load items
`default_nettype none

module mpbf_marker_table
	import mpbf_pkg::*;
#(
	parameter int NUM_MARKERS    = NUM_MARKERS_DEF,
	parameter int MAX_MARKER_LEN = MAX_MARKER_LEN_DEF,
	localparam int LEN_W = $clog2(MAX_MARKER_LEN + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire step_t             step,
	input  wire item_t             item,
	output logic [BYTE_W-1:0]      mark_bytes [NUM_MARKERS][MAX_MARKER_LEN],
	output logic [LEN_W-1:0]       mark_len [NUM_MARKERS]
);

	logic [LEN_W-1:0] len_sat;

	assign len_sat = (32'(item.plen) > MAX_MARKER_LEN) ? LEN_W'(MAX_MARKER_LEN)
		: LEN_W'(item.plen);

	// every load item rewrites the slot length, even when the byte is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MARKERS; m++)
				mark_len[m] <= '0;
		end else if (step.load) begin
			for (int m = 0; m < NUM_MARKERS; m++)
				if (32'(item.slot) == m)
					mark_len[m] <= len_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (step.load) begin
			for (int m = 0; m < NUM_MARKERS; m++)
				for (int k = 0; k < MAX_MARKER_LEN; k++)
					if (32'(item.slot) == m && 32'(item.offs) == k)
						mark_bytes[m][k] <= item.data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mpbf_window_match.sv =====
// sliding text window and parallel compare against every marker
`default_nettype none

module mpbf_window_match
	import mpbf_pkg::*;
#(
	parameter int NUM_MARKERS    = NUM_MARKERS_DEF,
	parameter int MAX_MARKER_LEN = MAX_MARKER_LEN_DEF,
	localparam int LEN_W = $clog2(MAX_MARKER_LEN + 1),
	localparam int AW    = (MAX_MARKER_LEN > 1) ? $clog2(MAX_MARKER_LEN) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire step_t             step,
	input  wire logic [BYTE_W-1:0] data,
	input  wire logic [CFG_W-1:0]  in_use,
	input  wire logic [BYTE_W-1:0] mark_bytes [NUM_MARKERS][MAX_MARKER_LEN],
	input  wire logic [LEN_W-1:0]  mark_len [NUM_MARKERS],
	output logic [NUM_MARKERS-1:0] hit
);

	// win[0] is the newest text byte
	logic [BYTE_W-1:0] win_q   [MAX_MARKER_LEN];
	logic [BYTE_W-1:0] win_new [MAX_MARKER_LEN];
	logic [LEN_W-1:0]  fill_q;
	logic [LEN_W-1:0]  fill_new;
	logic [AW-1:0]     sel_idx;
	logic [NUM_MARKERS-1:0] all_eq;

	always_comb begin
		win_new[0] = data;
		for (int i = 1; i < MAX_MARKER_LEN; i++)
			win_new[i] = win_q[i-1];
	end

	assign fill_new = (32'(fill_q) == MAX_MARKER_LEN) ? fill_q : fill_q + LEN_W'(1);

	// marker byte k lines up with the text byte that is len-1-k bytes old
	always_comb begin
		sel_idx = '0;
		for (int m = 0; m < NUM_MARKERS; m++) begin
			all_eq[m] = 1'b1;
			for (int k = 0; k < MAX_MARKER_LEN; k++) begin
				sel_idx = AW'(32'(mark_len[m]) - 1 - k);
				if (k < 32'(mark_len[m]) && (win_new[sel_idx] != mark_bytes[m][k]))
					all_eq[m] = 1'b0;
			end
			hit[m] = all_eq[m] && (mark_len[m] != '0) && (mark_len[m] <= fill_new)
				&& (m < 32'(in_use));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (step.scan) begin
			fill_q <= step.last ? '0 : fill_new;
		end
	end

	// bytes beyond the fill count are never compared
	always_ff @(posedge clk) begin
		if (step.scan) begin
			for (int i = 0; i < MAX_MARKER_LEN; i++)
				win_q[i] <= win_new[i];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mpbf_boundary_track.sv =====
// pending start table, open boundary, end-of-text flush and result register
`default_nettype none

module mpbf_boundary_track
	import mpbf_pkg::*;
#(
	parameter int NUM_MARKERS    = NUM_MARKERS_DEF,
	parameter int MAX_MARKER_LEN = MAX_MARKER_LEN_DEF,
	parameter int POS_BITS       = POS_BITS_DEF,
	localparam int LEN_W = $clog2(MAX_MARKER_LEN + 1),
	localparam int MW    = (NUM_MARKERS > 1) ? $clog2(NUM_MARKERS) : 1,
	localparam int TW    = (MAX_MARKER_LEN > 1) ? $clog2(MAX_MARKER_LEN) : 1,
	localparam int CW    = POS_BITS + 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire step_t               step,
	input  wire logic [NUM_MARKERS-1:0] hit,
	input  wire logic [LEN_W-1:0]    mark_len [NUM_MARKERS],
	output trk_status_t              status,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [MIDX_W-1:0]        marker_index,
	output logic [POS_BITS-1:0]      start_pos,
	output logic [POS_BITS-1:0]      end_pos,
	output logic                     last_of_run
);

	typedef enum logic [2:0] {
		ST_RUN   = 3'b001,
		ST_FLUSH = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [TW-1:0] tcnt_q, tcnt_d;

	// pend[j] holds the best marker starting j bytes before the newest byte
	logic          pend_v_q [MAX_MARKER_LEN];
	logic [MW-1:0] pend_m_q [MAX_MARKER_LEN];
	logic          sh_v     [MAX_MARKER_LEN];
	logic [MW-1:0] sh_m     [MAX_MARKER_LEN];
	logic          cand_v   [MAX_MARKER_LEN];
	logic [MW-1:0] cand_m   [MAX_MARKER_LEN];
	logic [LEN_W-1:0] cur_len [MAX_MARKER_LEN];
	logic          new_v    [MAX_MARKER_LEN];
	logic [MW-1:0] new_m    [MAX_MARKER_LEN];

	logic          open_v_q;
	logic [MW-1:0] open_m_q;
	logic [CW-1:0] open_s_q;
	logic [CW-1:0] pos_q;

	logic          out_v_q;
	logic [MIDX_W-1:0]   out_m_q;
	logic [POS_BITS-1:0] out_s_q;
	logic [POS_BITS-1:0] out_e_q;
	logic          out_l_q;

	logic          room;
	logic          adv;
	logic [CW-1:0] pos_inc;
	logic [CW-1:0] base;
	logic [TW-1:0] tsel;
	logic [CW-1:0] fin_s;
	logic          fin_v;
	logic [MW-1:0] fin_m;
	logic          emit;
	logic [CW-1:0] em_e;
	logic          em_l;

	function automatic logic [POS_BITS-1:0] clip_pos(input logic [CW-1:0] p);
		clip_pos = p[CW-1] ? '1 : p[POS_BITS-1:0];
	endfunction

	assign room    = !out_v_q || out_ready;
	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + CW'(1);

	always_comb begin
		sh_v[0] = 1'b0;
		sh_m[0] = '0;
		for (int j = 1; j < MAX_MARKER_LEN; j++) begin
			sh_v[j] = pend_v_q[j-1];
			sh_m[j] = pend_m_q[j-1];
		end
		for (int j = 0; j < MAX_MARKER_LEN; j++) begin
			// highest slot of this length wins
			cand_v[j] = 1'b0;
			cand_m[j] = '0;
			for (int m = 0; m < NUM_MARKERS; m++)
				if (step.scan && hit[m] && 32'(mark_len[m]) == j + 1) begin
					cand_v[j] = 1'b1;
					cand_m[j] = MW'(m);
				end
			cur_len[j] = mark_len[sh_m[j]];
			new_v[j] = sh_v[j];
			new_m[j] = sh_m[j];
			if (cand_v[j] && (!sh_v[j] || 32'(cur_len[j]) <= j + 1)) begin
				new_v[j] = 1'b1;
				new_m[j] = cand_m[j];
			end
		end
	end

	// the oldest start is final: nothing longer can still begin there
	assign fin_v = new_v[MAX_MARKER_LEN-1];
	assign fin_m = new_m[MAX_MARKER_LEN-1];
	assign base  = (state_q == ST_RUN) ? pos_inc : pos_q;
	assign tsel  = (state_q == ST_RUN) ? '0 : tcnt_q;
	assign fin_s = base - CW'(MAX_MARKER_LEN) + CW'(tsel);

	always_comb begin
		state_d = state_q;
		tcnt_d  = tcnt_q;
		adv     = 1'b0;
		emit    = 1'b0;
		em_e    = fin_s;
		em_l    = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				adv  = step.scan;
				emit = step.scan && fin_v && open_v_q;
				if (step.scan && step.last) begin
					tcnt_d  = TW'(1);
					state_d = (MAX_MARKER_LEN > 1) ? ST_FLUSH : ST_FINAL;
				end
			end
			ST_FLUSH: begin
				adv  = room;
				emit = fin_v && open_v_q;
				if (room) begin
					tcnt_d = tcnt_q + TW'(1);
					if (32'(tcnt_q) == MAX_MARKER_LEN - 1)
						state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				adv  = room;
				emit = open_v_q;
				em_e = pos_q;
				em_l = 1'b1;
				if (room)
					state_d = ST_RUN;
			end
			default: begin
				state_d = ST_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_RUN;
			tcnt_q   <= '0;
			pos_q    <= '0;
			open_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			for (int j = 0; j < MAX_MARKER_LEN; j++)
				pend_v_q[j] <= 1'b0;
		end else begin
			state_q <= state_d;
			tcnt_q  <= tcnt_d;
			if (room)
				out_v_q <= emit;
			if (adv) begin
				for (int j = 0; j < MAX_MARKER_LEN - 1; j++)
					pend_v_q[j] <= new_v[j];
				pend_v_q[MAX_MARKER_LEN-1] <= 1'b0;
				if (state_q == ST_FINAL)
					open_v_q <= 1'b0;
				else if (fin_v)
					open_v_q <= 1'b1;
				if (state_q == ST_RUN)
					pos_q <= pos_inc;
				else if (state_q == ST_FINAL)
					pos_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < MAX_MARKER_LEN; j++)
				pend_m_q[j] <= new_m[j];
			if (fin_v) begin
				open_m_q <= fin_m;
				open_s_q <= fin_s;
			end
		end
		if (room && emit) begin
			out_m_q <= MIDX_W'(open_m_q);
			out_s_q <= clip_pos(open_s_q);
			out_e_q <= clip_pos(em_e);
			out_l_q <= em_l;
		end
	end

	assign status.flushing = (state_q != ST_RUN);
	assign status.res_room = room;

	assign out_valid    = out_v_q;
	assign marker_index = out_m_q;
	assign start_pos    = out_s_q;
	assign end_pos      = out_e_q;
	assign last_of_run  = out_l_q;

endmodule

`default_nettype wire

// ===== hdl/multi_pattern_boundary_finder.sv =====
// a result is registered when the text item that finalizes it is taken
// throughput: one load or text item per cycle outside a flush; text items also need
// result room. A last text item starts a flush that drains pending starts, at most one
// result each and each waiting for room, before the next item is processed
// reset: asynchronous, clears lengths, window fill, pending starts and control; marker
// bytes are undefined until loaded, no clearing pass
`default_nettype none

module multi_pattern_boundary_finder
	import mpbf_pkg::*;
#(
	parameter int NUM_MARKERS    = NUM_MARKERS_DEF,
	parameter int MAX_MARKER_LEN = MAX_MARKER_LEN_DEF,
	parameter int POS_BITS       = POS_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                mode,
	input  wire logic [SLOT_W-1:0]   pattern_slot,
	input  wire logic [OFFS_W-1:0]   byte_offset,
	input  wire logic [PLEN_W-1:0]   pattern_length,
	input  wire logic [BYTE_W-1:0]   byte_value,
	input  wire logic                last,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [MIDX_W-1:0]        marker_index,
	output logic [POS_BITS-1:0]      start_pos,
	output logic [POS_BITS-1:0]      end_pos,
	output logic                     last_of_run,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CFG_W-1:0]    cfg_data
);

	localparam int LEN_W = $clog2(MAX_MARKER_LEN + 1);

	item_t           item_s1;
	logic            valid_s1;
	logic            take;
	step_t           step;
	trk_status_t     status;
	logic [CFG_W-1:0] in_use_q;

	logic [BYTE_W-1:0] mark_bytes [NUM_MARKERS][MAX_MARKER_LEN];
	logic [LEN_W-1:0]  mark_len [NUM_MARKERS];
	logic [NUM_MARKERS-1:0] hit;

	// load items need no room in the result register
	assign take = valid_s1 && !status.flushing
		&& (status.res_room || item_s1.mode == MODE_LOAD);
	assign in_ready  = !valid_s1 || take;
	assign cfg_ready = 1'b1;

	assign step.load = take && (item_s1.mode == MODE_LOAD);
	assign step.scan = take && (item_s1.mode == MODE_SCAN);
	assign step.last = item_s1.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			in_use_q <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (cfg_valid)
				in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.mode <= mode_t'(mode);
			item_s1.slot <= pattern_slot;
			item_s1.offs <= byte_offset;
			item_s1.plen <= pattern_length;
			item_s1.data <= byte_value;
			item_s1.last <= last;
		end
	end

	mpbf_marker_table #(
		.NUM_MARKERS    (NUM_MARKERS),
		.MAX_MARKER_LEN (MAX_MARKER_LEN)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item       (item_s1),
		.mark_bytes (mark_bytes),
		.mark_len   (mark_len)
	);

	mpbf_window_match #(
		.NUM_MARKERS    (NUM_MARKERS),
		.MAX_MARKER_LEN (MAX_MARKER_LEN)
	) u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data       (item_s1.data),
		.in_use     (in_use_q),
		.mark_bytes (mark_bytes),
		.mark_len   (mark_len),
		.hit        (hit)
	);

	mpbf_boundary_track #(
		.NUM_MARKERS    (NUM_MARKERS),
		.MAX_MARKER_LEN (MAX_MARKER_LEN),
		.POS_BITS       (POS_BITS)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.hit          (hit),
		.mark_len     (mark_len),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.marker_index (marker_index),
		.start_pos    (start_pos),
		.end_pos      (end_pos),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire
